// ===== src/htw_pkg.sv =====
// Shared constants for the hashed timing wheel timer table.
// Command, result kind and status codes, default sizes. No dependencies.
package htw_pkg;

    localparam int TIMER_ENTRIES_DEF = 32;
    localparam int WHEEL_SLOTS_DEF   = 256;
    localparam int SLOT_TIME_MS      = 16;

    localparam logic [31:0] MAX_U32 = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_ADD_LOOP  = 3'd0;
    localparam logic [2:0] CMD_ADD_COUNT = 3'd1;
    localparam logic [2:0] CMD_ADD_DELAY = 3'd2;
    localparam logic [2:0] CMD_REMOVE    = 3'd3;
    localparam logic [2:0] CMD_TICK      = 3'd4;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EXISTS = 2'd2;

endpackage

// ===== src/htw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/htw_div.sv =====
// Timer period to wheel placement: slot ticks split into rotation and slot offset.
// Depends on htw_pkg; SLOT_TIME_MS and WHEEL_SLOTS are powers of two, so both are shifts.
module htw_div #(
    parameter int WHEEL_SLOTS = htw_pkg::WHEEL_SLOTS_DEF
) (
    input  logic [31:0]                    period_ms,
    output logic [31:0]                    rotation,
    output logic [$clog2(WHEEL_SLOTS)-1:0] offset
);
    import htw_pkg::*;

    localparam int SW = $clog2(WHEEL_SLOTS);
    localparam int TW = $clog2(SLOT_TIME_MS);

    logic [31:0] ticks;

    assign ticks    = period_ms >> TW;
    assign rotation = ticks >> SW;
    assign offset   = ticks[SW-1:0];

endmodule

// ===== src/hashed_timing_wheel_timers.sv =====
// Hashed timing wheel timer table: sequencer, entry scan and result output.
// Depends on htw_pkg, htw_ram (entry store) and htw_div (period to slot placement).
//
// Usage: drive a command on cmd and the key/timing fields and pulse start while
// busy is low; the beat is taken at that edge. Results appear one per cycle
// at most, each for exactly one cycle with result_valid high; last marks the
// final result of the command. The receiver cannot stall the block.
// The scan reads each entry in two states, S_RD (address) and S_PROC (registered
// data), through the single RAM read port; one pass covers all TIMER_ENTRIES.
// Steps from the accepting edge to the final result:
// add: one pass, then a store in S_WRITE; a one-shot delay add scans twice
// (existing key, then removal), or ends after the first pass when the key
// already exists. Remove: one pass.
// Tick: fired results come out during the scan, at most one per entry, and
// the tick-finished result after it. Unknown commands: acked straight from idle.
// Busy drops in the cycle the final result is out, so the next command can be
// taken then. WHEEL_SLOTS must be a power of two. Reset empties the table and
// sets the current slot to zero; no clearing pass is needed.
module hashed_timing_wheel_timers #(
    parameter int TIMER_ENTRIES = htw_pkg::TIMER_ENTRIES_DEF,
    parameter int WHEEL_SLOTS   = htw_pkg::WHEEL_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [63:0] object_key,
    input  logic [63:0] data_key,
    input  logic [7:0]  owner,
    input  logic [31:0] interval_ms,
    input  logic [31:0] first_delay_ms,
    input  logic [31:0] repeat_count,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [63:0] fired_object,
    output logic [63:0] fired_data,
    output logic [7:0]  fired_owner,
    output logic [31:0] turn_number,
    output logic        last
);
    import htw_pkg::*;

    localparam int IW = $clog2(TIMER_ENTRIES);
    localparam int SW = $clog2(WHEEL_SLOTS);

    // entry record layout, low to high
    localparam int IOFF_LO = 0;
    localparam int IROT_LO = SW;
    localparam int TURN_LO = SW + 32;
    localparam int SLOT_LO = SW + 64;
    localparam int ROT_LO  = 2 * SW + 64;
    localparam int REM_LO  = 2 * SW + 96;
    localparam int LOOP_LO = 2 * SW + 128;
    localparam int OWN_LO  = 2 * SW + 129;
    localparam int DAT_LO  = 2 * SW + 137;
    localparam int OBJ_LO  = 2 * SW + 201;
    localparam int REC_W   = 2 * SW + 265;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_PROC  = 4'd6;
    localparam logic [3:0] S_WRITE = 4'd7;
    localparam logic [3:0] S_TEND  = 4'd8;

    localparam logic [1:0] P_EXIST  = 2'd0;
    localparam logic [1:0] P_REMOVE = 2'd1;
    localparam logic [1:0] P_TICK   = 2'd2;

    // control state
    logic [3:0]               state_reg, state_next;
    logic [1:0]               pass_reg,  pass_next;
    logic [IW-1:0]            idx_reg,   idx_next;
    logic [IW-1:0]            free_reg,  free_next;
    logic                     found_reg, found_next;
    logic                     hit_reg,   hit_next;
    logic [SW-1:0]            cur_reg,   cur_next;
    logic [TIMER_ENTRIES-1:0] valid_reg, valid_next;
    logic                     rv_reg,    rv_next;

    // payload
    logic [2:0]    cmd_reg,   cmd_next;
    logic [63:0]   obj_reg,   obj_next;
    logic [63:0]   dat_reg,   dat_next;
    logic [7:0]    own_reg,   own_next;
    logic [31:0]   cnt_reg,   cnt_next;
    logic [31:0]   irot_reg,  irot_next;
    logic [SW-1:0] ioff_reg,  ioff_next;
    logic [31:0]   frot_reg,  frot_next;
    logic [SW-1:0] foff_reg,  foff_next;
    logic [1:0]    kind_reg,  kind_next;
    logic [1:0]    stat_reg,  stat_next;
    logic [63:0]   fobj_reg,  fobj_next;
    logic [63:0]   fdat_reg,  fdat_next;
    logic [7:0]    fown_reg,  fown_next;
    logic [31:0]   turn_reg,  turn_next;
    logic          last_reg,  last_next;

    logic [REC_W-1:0] ram_rdata, ram_wdata;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;

    logic [31:0]   first_ms, i_rot, f_rot;
    logic [SW-1:0] i_off, f_off;

    logic [63:0]   d_obj, d_dat;
    logic [7:0]    d_own;
    logic          d_loop;
    logic [31:0]   d_rem, d_rot, d_turn, d_irot;
    logic [SW-1:0] d_slot, d_ioff;

    logic          vi, own_eq, obj_eq, dat_eq, rm_match, exists, in_slot, keep, last_idx;
    logic [31:0]   rem_dec, turn_inc, intv_adj;
    logic [SW-1:0] place_off, place_slot;
    logic [SW:0]   place_sum;

    htw_ram #(
        .WIDTH(REC_W),
        .DEPTH(TIMER_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    // re-arm placement from the interval, first placement from delay or interval
    htw_div #(
        .WHEEL_SLOTS(WHEEL_SLOTS)
    ) u_ivl_place (
        .period_ms(intv_adj),
        .rotation (i_rot),
        .offset   (i_off)
    );

    htw_div #(
        .WHEEL_SLOTS(WHEEL_SLOTS)
    ) u_first_place (
        .period_ms(first_ms),
        .rotation (f_rot),
        .offset   (f_off)
    );

    assign d_obj  = ram_rdata[OBJ_LO +: 64];
    assign d_dat  = ram_rdata[DAT_LO +: 64];
    assign d_own  = ram_rdata[OWN_LO +: 8];
    assign d_loop = ram_rdata[LOOP_LO];
    assign d_rem  = ram_rdata[REM_LO +: 32];
    assign d_rot  = ram_rdata[ROT_LO +: 32];
    assign d_slot = ram_rdata[SLOT_LO +: SW];
    assign d_turn = ram_rdata[TURN_LO +: 32];
    assign d_irot = ram_rdata[IROT_LO +: 32];
    assign d_ioff = ram_rdata[IOFF_LO +: SW];

    assign vi       = valid_reg[idx_reg];
    assign own_eq   = d_own == own_reg;
    assign obj_eq   = d_obj == obj_reg;
    assign dat_eq   = d_dat == dat_reg;
    assign rm_match = vi && own_eq && (obj_reg == 64'd0 || obj_eq)
                      && (dat_reg == 64'd0 || dat_eq);
    assign exists   = vi && own_eq && obj_eq && dat_eq;
    assign in_slot  = vi && (d_slot == cur_reg);
    assign rem_dec  = (d_rem != 32'd0) ? d_rem - 32'd1 : 32'd0;
    assign keep     = d_loop || (rem_dec != 32'd0);
    assign turn_inc = d_turn + 32'd1;
    assign last_idx = idx_reg == IW'(TIMER_ENTRIES - 1);
    assign intv_adj = (interval_ms != 32'd0) ? interval_ms :
                      ((cmd == CMD_ADD_LOOP) ? MAX_U32 : 32'd1);
    assign first_ms = (cmd == CMD_ADD_LOOP && first_delay_ms != 32'd0) ?
                      first_delay_ms : intv_adj;

    // (offset + current + 1) mod slots; both terms are below the slot count
    assign place_off  = (state_reg == S_WRITE) ? foff_reg : d_ioff;
    assign place_sum  = (SW + 1)'(place_off) + (SW + 1)'(cur_reg) + (SW + 1)'(1);
    assign place_slot = (place_sum >= (SW + 1)'(WHEEL_SLOTS)) ?
                        SW'(place_sum - (SW + 1)'(WHEEL_SLOTS)) : SW'(place_sum);

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        idx_next    = idx_reg;
        free_next   = free_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        cur_next    = cur_reg;
        valid_next  = valid_reg;
        rv_next     = 1'b0;
        cmd_next    = cmd_reg;
        obj_next    = obj_reg;
        dat_next    = dat_reg;
        own_next    = own_reg;
        cnt_next    = cnt_reg;
        irot_next   = irot_reg;
        ioff_next   = ioff_reg;
        frot_next   = frot_reg;
        foff_next   = foff_reg;
        kind_next   = kind_reg;
        stat_next   = stat_reg;
        fobj_next   = fobj_reg;
        fdat_next   = fdat_reg;
        fown_next   = fown_reg;
        turn_next   = turn_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    obj_next  = object_key;
                    dat_next  = data_key;
                    own_next  = owner;
                    cnt_next  = (cmd == CMD_ADD_LOOP) ? 32'd0 :
                                ((cmd == CMD_ADD_COUNT && repeat_count != 32'd0) ?
                                 repeat_count : 32'd1);
                    idx_next   = '0;
                    found_next = 1'b0;
                    hit_next   = 1'b0;
                    fobj_next  = '0;
                    fdat_next  = '0;
                    fown_next  = '0;
                    turn_next  = '0;
                    stat_next  = ST_OK;
                    if (cmd inside {CMD_ADD_LOOP, CMD_ADD_COUNT, CMD_ADD_DELAY})
                    begin
                        irot_next  = i_rot;
                        ioff_next  = i_off;
                        frot_next  = f_rot;
                        foff_next  = f_off;
                        pass_next  = (cmd == CMD_ADD_DELAY) ? P_EXIST : P_REMOVE;
                        state_next = S_RD;
                    end
                    else if (cmd == CMD_REMOVE)
                    begin
                        pass_next  = P_REMOVE;
                        state_next = S_RD;
                    end
                    else if (cmd == CMD_TICK)
                    begin
                        cur_next   = (cur_reg == SW'(WHEEL_SLOTS - 1)) ? '0 : cur_reg + SW'(1);
                        pass_next  = P_TICK;
                        state_next = S_RD;
                    end
                    else
                    begin
                        rv_next   = 1'b1;
                        kind_next = KIND_ACK;
                        last_next = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_PROC;
            end
            S_PROC:
            begin
                state_next = S_RD;
                idx_next   = idx_reg + IW'(1);
                case (pass_reg)
                    P_EXIST:
                    begin
                        if (exists)
                        begin
                            hit_next = 1'b1;
                        end
                        if (last_idx)
                        begin
                            idx_next = '0;
                            if (hit_next)
                            begin
                                rv_next    = 1'b1;
                                kind_next  = KIND_ACK;
                                stat_next  = ST_EXISTS;
                                last_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                pass_next = P_REMOVE;
                            end
                        end
                    end
                    P_REMOVE:
                    begin
                        if (rm_match)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                        // lowest entry left empty after the removal
                        if ((!vi || rm_match) && !found_reg)
                        begin
                            found_next = 1'b1;
                            free_next  = idx_reg;
                        end
                        if (last_idx)
                        begin
                            if (cmd_reg != CMD_REMOVE && found_next)
                            begin
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                rv_next    = 1'b1;
                                kind_next  = KIND_ACK;
                                stat_next  = (cmd_reg == CMD_REMOVE) ? ST_OK : ST_FULL;
                                last_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        if (in_slot)
                        begin
                            ram_we = 1'b1;
                            if (d_rot != 32'd0)
                            begin
                                ram_wdata[ROT_LO +: 32] = d_rot - 32'd1;
                            end
                            else
                            begin
                                rv_next   = 1'b1;
                                kind_next = KIND_FIRED;
                                stat_next = ST_OK;
                                fobj_next = d_obj;
                                fdat_next = d_dat;
                                fown_next = d_own;
                                turn_next = turn_inc;
                                last_next = 1'b0;
                                ram_wdata[TURN_LO +: 32] = turn_inc;
                                ram_wdata[REM_LO +: 32]  = d_loop ? d_rem : rem_dec;
                                ram_wdata[ROT_LO +: 32]  = d_irot;
                                ram_wdata[SLOT_LO +: SW] = place_slot;
                                if (!keep)
                                begin
                                    valid_next[idx_reg] = 1'b0;
                                end
                            end
                        end
                        if (last_idx)
                        begin
                            state_next = S_TEND;
                        end
                    end
                endcase
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = free_reg;
                ram_wdata = {obj_reg, dat_reg, own_reg, cmd_reg == CMD_ADD_LOOP, cnt_reg,
                             frot_reg, place_slot, 32'd0, irot_reg, ioff_reg};
                valid_next[free_reg] = 1'b1;
                rv_next    = 1'b1;
                kind_next  = KIND_ACK;
                stat_next  = ST_OK;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_TEND:
            begin
                rv_next    = 1'b1;
                kind_next  = KIND_TICK;
                stat_next  = ST_OK;
                fobj_next  = '0;
                fdat_next  = '0;
                fown_next  = '0;
                turn_next  = '0;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pass_reg   <= P_EXIST;
            idx_reg    <= '0;
            free_reg   <= '0;
            found_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            cur_reg    <= '0;
            valid_reg  <= '0;
            rv_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass_reg   <= pass_next;
            idx_reg    <= idx_next;
            free_reg   <= free_next;
            found_reg  <= found_next;
            hit_reg    <= hit_next;
            cur_reg    <= cur_next;
            valid_reg  <= valid_next;
            rv_reg     <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        obj_reg   <= obj_next;
        dat_reg   <= dat_next;
        own_reg   <= own_next;
        cnt_reg   <= cnt_next;
        irot_reg  <= irot_next;
        ioff_reg  <= ioff_next;
        frot_reg  <= frot_next;
        foff_reg  <= foff_next;
        kind_reg  <= kind_next;
        stat_reg  <= stat_next;
        fobj_reg  <= fobj_next;
        fdat_reg  <= fdat_next;
        fown_reg  <= fown_next;
        turn_reg  <= turn_next;
        last_reg  <= last_next;
    end

    assign busy         = state_reg != S_IDLE;
    assign result_valid = rv_reg;
    assign kind         = kind_reg;
    assign status       = stat_reg;
    assign fired_object = fobj_reg;
    assign fired_data   = fdat_reg;
    assign fired_owner  = fown_reg;
    assign turn_number  = turn_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final result while sequencer still busy");

    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !busy |-> last)
        else $error("non-final result after command finished");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SW + 1)'(cur_reg) < (SW + 1)'(WHEEL_SLOTS))
        else $error("current slot out of range");

    a_fired_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_FIRED |-> busy && !last)
        else $error("fired result outside a tick scan");
`endif

endmodule
